FILE: rtl/sequential_readahead_policy_unit_defines.svh
// assertion macros for the readahead policy unit
// used by the top level only, relies on clk_i and rst_ni in scope
`ifndef SEQUENTIAL_READAHEAD_POLICY_UNIT_DEFINES_SVH
`define SEQUENTIAL_READAHEAD_POLICY_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define SRA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sra: same-cycle check failed");

// next-cycle implication, off during reset
`define SRA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sra: next-cycle check failed");

`endif

FILE: rtl/sra_pkg.sv
// shared types, constants and helpers of the readahead policy unit
// no dependencies
package sra_pkg;

  localparam int unsigned ADDR_W = 48;
  localparam int unsigned LEN_W  = 21;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned CFG_W  = 48;

  localparam logic [ADDR_W-1:0] ADDR_MAX    = '1;
  localparam logic [ADDR_W-1:0] PAGE_BYTES  = 48'd4096;
  localparam logic [ADDR_W-1:0] SLACK_BYTES = 48'd65536;
  localparam logic [LEN_W-1:0]  MIN_WINDOW  = 21'd65536;
  localparam logic [LEN_W-1:0]  MAX_WINDOW  = 21'd1048576;

  typedef enum logic {
    OP_READ   = 1'b0,
    OP_ANSWER = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ACT_NONE     = 2'd0,
    ACT_PREFETCH = 2'd1,
    ACT_PROBE    = 2'd2,
    ACT_REJECT   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    MODE_PROBE     = 2'd0,
    MODE_ACTIVE    = 2'd1,
    MODE_SUSPENDED = 2'd2
  } mode_e;

  // internal readahead mode, one-hot
  typedef enum logic [2:0] {
    ST_PROBE     = 3'b001,
    ST_ACTIVE    = 3'b010,
    ST_SUSPENDED = 3'b100
  } mode_state_e;

  typedef enum logic [IDX_W-1:0] {
    REG_REGION_SIZE     = 2'd0,
    REG_READAHEAD_LIMIT = 2'd1,
    REG_START_PROBING   = 2'd2
  } reg_idx_e;

  // registered input word, with the saturated read end precomputed
  typedef struct packed {
    opcode_e           opcode;
    logic [ADDR_W-1:0] read_offset;
    logic [ADDR_W-1:0] read_length;
    logic              range_resident;
    logic [ADDR_W-1:0] read_end;
  } item_t;

  typedef struct packed {
    action_e           action;
    logic [ADDR_W-1:0] range_start;
    logic [LEN_W-1:0]  range_length;
    mode_e             mode;
  } result_t;

  typedef struct packed {
    logic probe_pending;
  } status_t;

  function automatic logic [ADDR_W-1:0] sat_add(input logic [ADDR_W-1:0] a,
                                                input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ADDR_W] ? ADDR_MAX : s[ADDR_W-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] grow_window(input logic [LEN_W-1:0] w);
    logic [LEN_W:0] d;
    d = {w, 1'b0};
    return (d > {1'b0, MAX_WINDOW}) ? MAX_WINDOW : d[LEN_W-1:0];
  endfunction

  function automatic mode_e mode_code(input mode_state_e st);
    mode_e m;
    case (st)
      ST_PROBE:     m = MODE_PROBE;
      ST_ACTIVE:    m = MODE_ACTIVE;
      ST_SUSPENDED: m = MODE_SUSPENDED;
      default:      m = MODE_PROBE;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/sra_if.sv
// valid/ready channels of the readahead policy unit
// depends on sra_pkg
interface sra_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [sra_pkg::ADDR_W-1:0] read_offset;
  logic [sra_pkg::ADDR_W-1:0] read_length;
  logic                       range_resident;

  modport source (output valid, opcode, read_offset, read_length, range_resident,
                  input ready);
  modport sink (input valid, opcode, read_offset, read_length, range_resident,
                output ready);
endinterface

interface sra_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 action;
  logic [sra_pkg::ADDR_W-1:0] range_start;
  logic [sra_pkg::LEN_W-1:0]  range_length;
  logic [1:0]                 mode;

  modport source (output valid, action, range_start, range_length, mode,
                  input ready);
  modport sink (input valid, action, range_start, range_length, mode,
                output ready);
endinterface

FILE: rtl/sra_in_stage.sv
// input register of the readahead policy unit, precomputes the read end
// depends on sra_pkg and sra_in_if
module sra_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  sra_in_if.sink         evt_i,
  input  logic           advance_i,
  output logic           valid_o,
  output sra_pkg::item_t item_o
);

  logic           valid_q;
  logic           accept;
  sra_pkg::item_t item_d;
  sra_pkg::item_t item_q;

  // take a new word when empty or whenever the held one moves on
  assign evt_i.ready = !valid_q || advance_i;
  assign accept      = evt_i.valid && evt_i.ready;

  always_comb begin
    item_d.opcode         = sra_pkg::opcode_e'(evt_i.opcode);
    item_d.read_offset    = evt_i.read_offset;
    item_d.read_length    = evt_i.read_length;
    item_d.range_resident = evt_i.range_resident;
    item_d.read_end       = sra_pkg::sat_add(evt_i.read_offset, evt_i.read_length);
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: rtl/sra_policy.sv
// run tracking, prefetch decision and configuration registers
// depends on sra_pkg
module sra_policy (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sra_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [sra_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        fire_i,
  input  sra_pkg::item_t              item_i,
  output sra_pkg::result_t            result_o,
  output sra_pkg::status_t            status_o
);

  localparam int unsigned AW = sra_pkg::ADDR_W;
  localparam int unsigned LW = sra_pkg::LEN_W;

  // configuration
  logic [AW-1:0] region_q;
  logic [AW-1:0] limit_q;

  // policy state
  logic                 run_started_q, run_started_d;
  logic [AW-1:0]        run_end_q, run_end_d;
  logic [AW-1:0]        run_bytes_q, run_bytes_d;
  logic [AW-1:0]        skipped_q, skipped_d;
  logic [LW-1:0]        window_q, window_d;
  logic [AW-1:0]        pref_end_q, pref_end_d;
  sra_pkg::mode_state_e mode_q, mode_d;
  logic                 pending_q, pending_d;
  logic [AW-1:0]        pend_start_q, pend_start_d;
  logic [LW-1:0]        pend_len_q, pend_len_d;

  // run tracking after a read
  logic          run_started_n;
  logic [AW-1:0] run_end_n, run_bytes_n, skipped_n;
  logic [LW-1:0] window_n;
  logic [AW-1:0] gap, ext;
  logic [AW+1:0] run_sum3;

  // decision terms
  logic          dense, near, want;
  logic [AW-1:0] lim, from, room;
  logic [LW-1:0] len;

  sra_pkg::action_e   action;
  logic [AW-1:0]      out_start;
  logic [LW-1:0]      out_len;

  assign gap      = item_i.read_offset - run_end_q;
  assign ext      = item_i.read_end - run_end_q;
  assign run_sum3 = {2'b00, run_bytes_q} + {2'b00, gap} + {2'b00, item_i.read_length};

  // extend the sequential run
  always_comb begin
    run_started_n = run_started_q;
    run_end_n     = run_end_q;
    run_bytes_n   = run_bytes_q;
    skipped_n     = skipped_q;
    window_n      = window_q;
    if (!run_started_q) begin
      run_started_n = 1'b1;
      run_bytes_n   = item_i.read_length;
      skipped_n     = '0;
      window_n      = sra_pkg::MIN_WINDOW;
      run_end_n     = item_i.read_end;
    end else if (item_i.read_offset >= run_end_q) begin
      if (gap >= sra_pkg::PAGE_BYTES) begin
        skipped_n   = sra_pkg::sat_add(skipped_q, gap);
        run_bytes_n = sra_pkg::sat_add(run_bytes_q, item_i.read_length);
      end else begin
        run_bytes_n = (|run_sum3[AW+1:AW]) ? sra_pkg::ADDR_MAX : run_sum3[AW-1:0];
      end
      run_end_n = item_i.read_end;
    end else if (item_i.read_end > run_end_q) begin
      run_bytes_n = sra_pkg::sat_add(run_bytes_q, ext);
      run_end_n   = item_i.read_end;
    end
  end

  // prefetch range from the updated run
  assign dense = {run_bytes_n, 1'b0} >= {1'b0, skipped_n};
  assign near  = (pref_end_q <= run_end_n) ||
                 ((pref_end_q - run_end_n) < sra_pkg::SLACK_BYTES);
  assign want  = (mode_q != sra_pkg::ST_SUSPENDED) &&
                 (run_bytes_n >= sra_pkg::PAGE_BYTES) && dense && near;
  assign lim   = (region_q < limit_q) ? region_q : limit_q;
  assign from  = (pref_end_q > item_i.read_offset) ? pref_end_q : item_i.read_offset;
  assign room  = lim - from;
  assign len   = ({{(AW-LW){1'b0}}, window_n} < room) ? window_n : room[LW-1:0];

  // next state and result for one word
  always_comb begin
    run_started_d = run_started_q;
    run_end_d     = run_end_q;
    run_bytes_d   = run_bytes_q;
    skipped_d     = skipped_q;
    window_d      = window_q;
    pref_end_d    = pref_end_q;
    mode_d        = mode_q;
    pending_d     = pending_q;
    pend_start_d  = pend_start_q;
    pend_len_d    = pend_len_q;
    action        = sra_pkg::ACT_NONE;
    out_start     = '0;
    out_len       = '0;
    if (item_i.opcode == sra_pkg::OP_ANSWER) begin
      // residency answer
      if (pending_q) begin
        pending_d = 1'b0;
        if (item_i.range_resident) begin
          mode_d = sra_pkg::ST_SUSPENDED;
        end else begin
          mode_d     = sra_pkg::ST_ACTIVE;
          pref_end_d = sra_pkg::sat_add(pend_start_q, {{(AW-LW){1'b0}}, pend_len_q});
          window_d   = sra_pkg::grow_window(window_q);
          action     = sra_pkg::ACT_PREFETCH;
          out_start  = pend_start_q;
          out_len    = pend_len_q;
        end
      end
    end else if (pending_q) begin
      action = sra_pkg::ACT_REJECT;
    end else begin
      // read event
      run_started_d = run_started_n;
      run_end_d     = run_end_n;
      run_bytes_d   = run_bytes_n;
      skipped_d     = skipped_n;
      window_d      = window_n;
      if (want && (from < lim)) begin
        out_start = from;
        out_len   = len;
        if (mode_q == sra_pkg::ST_PROBE) begin
          pending_d    = 1'b1;
          pend_start_d = from;
          pend_len_d   = len;
          action       = sra_pkg::ACT_PROBE;
        end else begin
          pref_end_d = from + {{(AW-LW){1'b0}}, len};
          window_d   = sra_pkg::grow_window(window_n);
          action     = sra_pkg::ACT_PREFETCH;
        end
      end
    end
  end

  // state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q      <= '0;
      limit_q       <= sra_pkg::ADDR_MAX;
      run_started_q <= 1'b0;
      run_end_q     <= '0;
      run_bytes_q   <= '0;
      skipped_q     <= '0;
      window_q      <= sra_pkg::MIN_WINDOW;
      pref_end_q    <= '0;
      mode_q        <= sra_pkg::ST_PROBE;
      pending_q     <= 1'b0;
      pend_start_q  <= '0;
      pend_len_q    <= '0;
    end else begin
      if (fire_i) begin
        run_started_q <= run_started_d;
        run_end_q     <= run_end_d;
        run_bytes_q   <= run_bytes_d;
        skipped_q     <= skipped_d;
        window_q      <= window_d;
        pref_end_q    <= pref_end_d;
        mode_q        <= mode_d;
        pending_q     <= pending_d;
        pend_start_q  <= pend_start_d;
        pend_len_q    <= pend_len_d;
      end
      if (cfg_we_i) begin
        case (sra_pkg::reg_idx_e'(cfg_idx_i))
          sra_pkg::REG_REGION_SIZE: begin
            region_q <= cfg_data_i[AW-1:0];
          end
          sra_pkg::REG_READAHEAD_LIMIT: begin
            limit_q <= cfg_data_i[AW-1:0];
          end
          sra_pkg::REG_START_PROBING: begin
            mode_q       <= cfg_data_i[0] ? sra_pkg::ST_PROBE : sra_pkg::ST_ACTIVE;
            pending_q    <= 1'b0;
            pend_start_q <= '0;
            pend_len_q   <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    result_o.action       = action;
    result_o.range_start  = out_start;
    result_o.range_length = out_len;
    result_o.mode         = sra_pkg::mode_code(mode_d);
  end

  assign status_o.probe_pending = pending_q;

endmodule

FILE: rtl/sra_out_stage.sv
// result register of the readahead policy unit
// depends on sra_pkg and sra_out_if
module sra_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  sra_pkg::result_t result_i,
  output logic             advance_o,
  sra_out_if.source        res_o
);

  logic             valid_q;
  sra_pkg::result_t result_q;

  // the register frees up when empty or when its word is taken
  assign advance_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && valid_i) begin
      result_q <= result_i;
    end
  end

  assign res_o.valid        = valid_q;
  assign res_o.action       = result_q.action;
  assign res_o.range_start  = result_q.range_start;
  assign res_o.range_length = result_q.range_length;
  assign res_o.mode         = result_q.mode;

endmodule

FILE: rtl/sequential_readahead_policy_unit.sv
// top level of the sequential readahead policy unit
// depends on sra_pkg, sra_if, sra_in_stage, sra_policy, sra_out_stage and the defines header
//
//   channel  dir  handshake      word
//   evt_i    in   valid/ready    opcode, read_offset, read_length, range_resident
//   res_o    out  valid/ready    action, range_start, range_length, mode
//   cfg      in   cfg_we_i only  cfg_idx_i, cfg_data_i
//
// one word per cycle sustained while the result side does not stall; a result
// passes the input register, then the result register, before it is valid
// the state update is combinational through the policy compare/add logic and registered as the word moves on
// no clearing after reset: ready is up straight out of reset
// a stalled result holds its register, the input register keeps the next word,
// and ready drops only when both are full
`include "sequential_readahead_policy_unit_defines.svh"

module sequential_readahead_policy_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [sra_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [sra_pkg::CFG_W-1:0] cfg_data_i,
  sra_in_if.sink                    evt_i,
  sra_out_if.source                 res_o
);

  logic             s1_valid;
  logic             advance;
  logic             s1_fire;
  sra_pkg::item_t   s1_item;
  sra_pkg::result_t result;
  sra_pkg::status_t status;

  // terms used by the checks below
  logic             rd_on_pending;
  logic             res_empty;
  logic             res_probe;

  assign s1_fire = s1_valid && advance;

  // input register
  sra_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .evt_i     (evt_i),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  // policy state and decision
  sra_policy u_policy (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (s1_fire),
    .item_i     (s1_item),
    .result_o   (result),
    .status_o   (status)
  );

  // result register
  sra_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s1_valid),
    .result_i  (result),
    .advance_o (advance),
    .res_o     (res_o)
  );

  assign rd_on_pending = s1_fire && (s1_item.opcode == sra_pkg::OP_READ) &&
                         status.probe_pending;
  assign res_empty     = res_o.valid && ((res_o.action == sra_pkg::ACT_NONE) ||
                                         (res_o.action == sra_pkg::ACT_REJECT));
  assign res_probe     = res_o.valid && (res_o.action == sra_pkg::ACT_PROBE);

  // a read that meets a pending probe comes back rejected
  `SRA_ASSERT_NEXT(a_reject_pending, rd_on_pending, res_o.valid && res_o.action == sra_pkg::ACT_REJECT)
  // no range on a word without prefetch or probe
  `SRA_ASSERT_NOW(a_empty_range, res_empty, (res_o.range_start == '0) && (res_o.range_length == '0))
  // a probe leaves the unit in probe mode
  `SRA_ASSERT_NOW(a_probe_mode, res_probe, res_o.mode == sra_pkg::MODE_PROBE)
  // input backpressure only comes from a stalled result
  `SRA_ASSERT_NOW(a_stall_source, !evt_i.ready, res_o.valid && !res_o.ready)

endmodule

FILE: tb/testbench.sv
// testbench of the sequential readahead policy unit: directed cases, then random
// phases of read streams; a scoreboard class predicts every result word
// depends on sra_pkg, sra_if and the top level sequential_readahead_policy_unit
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sra_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned PHASE_WORDS  = 170;
  localparam int unsigned N_PHASES     = 10;

  // predictor of the readahead policy plus the queue of expected result words
  class readahead_scoreboard;
    logic [ADDR_W-1:0] region_size;
    logic [ADDR_W-1:0] ra_limit;
    logic              probe_on_start;

    bit                run_started;
    logic [ADDR_W-1:0] run_end;
    logic [ADDR_W-1:0] run_bytes;
    logic [ADDR_W-1:0] skipped_bytes;
    logic [LEN_W-1:0]  window_bytes;
    logic [ADDR_W-1:0] prefetched_end;
    mode_e             mode;
    bit                probe_pending;
    logic [ADDR_W-1:0] pending_start;
    logic [LEN_W-1:0]  pending_length;

    result_t           expected_q[$];
    int unsigned       errors, n_words, n_prefetch, n_probe, n_reject;

    function new();
      region_size    = '0;
      ra_limit       = ADDR_MAX;
      probe_on_start = 1'b1;
      run_started    = 1'b0;
      run_end        = '0;
      run_bytes      = '0;
      skipped_bytes  = '0;
      window_bytes   = MIN_WINDOW;
      prefetched_end = '0;
      mode           = MODE_PROBE;
      probe_pending  = 1'b0;
      pending_start  = '0;
      pending_length = '0;
      errors         = 0;
      n_words        = 0;
      n_prefetch     = 0;
      n_probe        = 0;
      n_reject       = 0;
    endfunction

    function logic [ADDR_W-1:0] add_clamped(logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] b);
      logic [ADDR_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[ADDR_W] ? ADDR_MAX : s[ADDR_W-1:0];
    endfunction

    function void widen_window();
      logic [LEN_W:0] dbl;
      dbl = {window_bytes, 1'b0};
      window_bytes = (dbl > {1'b0, MAX_WINDOW}) ? MAX_WINDOW : dbl[LEN_W-1:0];
    endfunction

    function void write_reg(reg_idx_e idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_REGION_SIZE: region_size = data[ADDR_W-1:0];
        REG_READAHEAD_LIMIT: ra_limit = data[ADDR_W-1:0];
        REG_START_PROBING: begin
          // mode reloads and any probe in flight is dropped
          probe_on_start = data[0];
          mode           = data[0] ? MODE_PROBE : MODE_ACTIVE;
          probe_pending  = 1'b0;
          pending_start  = '0;
          pending_length = '0;
        end
        default: ;
      endcase
    endfunction

    // returns 0 for words that the unit only rejects or ignores
    function bit note_word(opcode_e op, logic [ADDR_W-1:0] rd_off, logic [ADDR_W-1:0] rd_len,
                           logic resident);
      result_t           r;
      logic [ADDR_W-1:0] rd_end, gap, lim, from, room, span;
      bit                took;
      r.action       = ACT_NONE;
      r.range_start  = '0;
      r.range_length = '0;
      took           = 1'b1;
      n_words++;
      if (op == OP_ANSWER) begin
        if (!probe_pending) begin
          took = 1'b0;
        end else begin
          probe_pending = 1'b0;
          if (resident) begin
            mode = MODE_SUSPENDED;
          end else begin
            mode           = MODE_ACTIVE;
            prefetched_end = add_clamped(pending_start, ADDR_W'(pending_length));
            widen_window();
            r.action       = ACT_PREFETCH;
            r.range_start  = pending_start;
            r.range_length = pending_length;
          end
        end
      end else if (probe_pending) begin
        r.action = ACT_REJECT;
        took     = 1'b0;
      end else begin
        // run tracking
        rd_end = add_clamped(rd_off, rd_len);
        if (!run_started) begin
          run_started   = 1'b1;
          run_bytes     = rd_len;
          skipped_bytes = '0;
          window_bytes  = MIN_WINDOW;
          run_end       = rd_end;
        end else if (rd_off >= run_end) begin
          gap = rd_off - run_end;
          if (gap >= PAGE_BYTES) skipped_bytes = add_clamped(skipped_bytes, gap);
          else run_bytes = add_clamped(run_bytes, gap);
          run_bytes = add_clamped(run_bytes, rd_len);
          run_end   = rd_end;
        end else if (rd_end > run_end) begin
          run_bytes = add_clamped(run_bytes, rd_end - run_end);
          run_end   = rd_end;
        end
        // prefetch decision
        if (mode != MODE_SUSPENDED && run_bytes >= PAGE_BYTES &&
            {run_bytes, 1'b0} >= {1'b0, skipped_bytes} &&
            (prefetched_end <= run_end || prefetched_end - run_end < SLACK_BYTES)) begin
          lim  = (region_size < ra_limit) ? region_size : ra_limit;
          from = (prefetched_end > rd_off) ? prefetched_end : rd_off;
          if (from < lim) begin
            room = lim - from;
            span = (ADDR_W'(window_bytes) < room) ? ADDR_W'(window_bytes) : room;
            r.range_start  = from;
            r.range_length = span[LEN_W-1:0];
            if (mode == MODE_PROBE) begin
              probe_pending  = 1'b1;
              pending_start  = from;
              pending_length = span[LEN_W-1:0];
              r.action       = ACT_PROBE;
            end else begin
              prefetched_end = from + span;
              widen_window();
              r.action = ACT_PREFETCH;
            end
          end
        end
      end
      r.mode = mode;
      case (r.action)
        ACT_PREFETCH: n_prefetch++;
        ACT_PROBE:    n_probe++;
        ACT_REJECT:   n_reject++;
        default: ;
      endcase
      expected_q.push_back(r);
      return took;
    endfunction

    function void check_word(result_t got);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: action %0d", got.action);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.action !== exp_r.action) begin
        $error("action: expected %0d, got %0d", exp_r.action, got.action);
        errors++;
      end
      if (got.range_start !== exp_r.range_start) begin
        $error("range_start: expected %0h, got %0h", exp_r.range_start, got.range_start);
        errors++;
      end
      if (got.range_length !== exp_r.range_length) begin
        $error("range_length: expected %0h, got %0h", exp_r.range_length, got.range_length);
        errors++;
      end
      if (got.mode !== exp_r.mode) begin
        $error("mode: expected %0d, got %0d", exp_r.mode, got.mode);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;
  bit               calm;
  int unsigned      cycles;

  sra_in_if  evt_if ();
  sra_out_if res_if ();

  readahead_scoreboard sb = new();

  sequential_readahead_policy_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .evt_i      (evt_if),
    .res_o      (res_if)
  );

  // clock
  always #1 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, sb.expected_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random stalls, check each accepted word
  always @(negedge clk_i) begin
    res_if.ready <= calm || ($urandom_range(99) >= 14);
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.action       = action_e'(res_if.action);
      got.range_start  = res_if.range_start;
      got.range_length = res_if.range_length;
      got.mode         = mode_e'(res_if.mode);
      sb.check_word(got);
    end
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[ADDR_W-1:0];
  endfunction

  // send one word, now and then with a random gap ahead of it outside calm phases
  task automatic put_word(input opcode_e op, input logic [ADDR_W-1:0] rd_off,
                          input logic [ADDR_W-1:0] rd_len, input logic resident,
                          output bit took);
    int unsigned n;
    if (!calm && $urandom_range(99) < 14) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        @(negedge clk_i);
        evt_if.valid          <= 1'b0;
        evt_if.opcode         <= 1'($urandom_range(1));
        evt_if.read_offset    <= rand_addr();
        evt_if.read_length    <= rand_addr();
        evt_if.range_resident <= 1'($urandom_range(1));
        @(posedge clk_i);
      end
    end
    @(negedge clk_i);
    evt_if.valid          <= 1'b1;
    evt_if.opcode         <= op;
    evt_if.read_offset    <= rd_off;
    evt_if.read_length    <= rd_len;
    evt_if.range_resident <= resident;
    do @(posedge clk_i); while (!evt_if.ready);
    took = sb.note_word(op, rd_off, rd_len, resident);
  endtask

  task automatic read_at(input logic [ADDR_W-1:0] rd_off, input logic [ADDR_W-1:0] rd_len);
    bit took;
    put_word(OP_READ, rd_off, rd_len, 1'($urandom_range(1)), took);
  endtask

  // read that continues the current run after a gap
  task automatic read_on(input logic [ADDR_W-1:0] gap, input logic [ADDR_W-1:0] rd_len);
    read_at(sb.run_end + gap, rd_len);
  endtask

  task automatic answer(input logic resident);
    bit took;
    put_word(OP_ANSWER, rand_addr(), rand_addr(), resident, took);
  endtask

  // hold the sender until every result word is back, then let the pipe settle
  task automatic drain();
    @(negedge clk_i);
    evt_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input reg_idx_e idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_probing(input bit probing);
    logic [CFG_W-1:0] v;
    v    = rand_addr();
    v[0] = probing;
    write_cfg(REG_START_PROBING, v);
  endtask

  // short hand-picked sequence through every mode and action
  task automatic directed_part();
    // stray answer with random fields, then the first read of the run
    answer(1'b1);
    read_at('0, 48'd8192);
    drain();
    write_cfg(REG_REGION_SIZE, 48'h1_0000_0000);
    write_cfg(REG_READAHEAD_LIMIT, ADDR_MAX);
    write_probing(1'b1);
    // probe, reject while pending, answer not resident, stray answer
    read_on('0, 48'd4096);
    read_at(ADDR_MAX, ADDR_MAX);
    answer(1'b0);
    answer(1'b0);
    // contiguous, page gap, small gap, inner read, overlapping read
    read_on('0, 48'd4096);
    read_on(48'd4096, 48'd4096);
    read_on(48'd100, 48'd4096);
    read_at(sb.run_end - 48'd2048, 48'd1024);
    read_at(sb.run_end - 48'd1000, 48'd200000);
    read_on('0, '0);
    drain();
    // limit of zero blocks prefetch
    write_cfg(REG_READAHEAD_LIMIT, '0);
    read_on('0, 48'd4096);
    drain();
    // probe answered resident: suspended, reads still tracked
    write_cfg(REG_READAHEAD_LIMIT, ADDR_MAX);
    write_probing(1'b1);
    read_on('0, 48'd2097152);
    answer(1'b1);
    read_on('0, 48'd2097152);
    drain();
    // prefetch start at the region end, then clamped by the region end
    write_probing(1'b0);
    write_cfg(REG_REGION_SIZE, sb.run_end);
    read_on('0, 48'd4096);
    drain();
    write_cfg(REG_REGION_SIZE, sb.run_end + 48'd5096);
    read_on('0, 48'd4096);
    drain();
  endtask

  // one random phase: fresh settings, then mostly well-formed read streams
  task automatic random_phase(input int unsigned p, input bit noisy);
    logic [ADDR_W-1:0] region, lim, rd_off, rd_len, gap, back;
    bit                probing, took, paused;
    int unsigned       done, c;
    drain();
    case ($urandom_range(3))
      0: region = ADDR_MAX;
      1: region = sb.run_end + ADDR_W'($urandom_range(0, 1 << 22));
      2: region = rand_addr();
      default: region = sb.run_end + 48'h4000_0000;
    endcase
    case ($urandom_range(3))
      0, 1: lim = ADDR_MAX;
      2: lim = sb.run_end + ADDR_W'($urandom_range(0, 1 << 23));
      default: lim = rand_addr();
    endcase
    probing = 1'($urandom_range(1));
    if (p == 0) probing = 1'b1;
    if (p == 1) begin
      region  = '0;
      probing = 1'b0;
    end
    if (p == 2) begin
      region = ADDR_MAX;
      lim    = ADDR_MAX;
    end
    if (p == 5) lim = '0;
    write_cfg(REG_REGION_SIZE, region);
    write_cfg(REG_READAHEAD_LIMIT, lim);
    write_probing(probing);
    calm   = (p == 4);
    paused = 1'b0;
    done   = 0;
    // the noisy phase opens with a read whose end runs past 48 bits
    if (noisy) begin
      put_word(OP_READ, sb.run_end, ADDR_MAX, 1'b0, took);
      done++;
    end
    while (done < PHASE_WORDS) begin
      c = $urandom_range(99);
      if (sb.probe_pending && $urandom_range(99) < 85) begin
        put_word(OP_ANSWER, rand_addr(), rand_addr(), $urandom_range(99) < 25, took);
      end else if (c < 4) begin
        put_word(OP_ANSWER, rand_addr(), rand_addr(), 1'($urandom_range(1)), took);
      end else if (noisy && c < 44) begin
        put_word(OP_READ, rand_addr(), rand_addr(), 1'($urandom_range(1)), took);
      end else if (c < 10) begin
        // read that starts inside the run
        back   = ADDR_W'($urandom_range(0, 65536));
        rd_off = (sb.run_end > back) ? sb.run_end - back : '0;
        put_word(OP_READ, rd_off, ADDR_W'($urandom_range(0, 131072)), 1'($urandom_range(1)),
                 took);
      end else begin
        c = $urandom_range(199);
        if (c < 140) gap = '0;
        else if (c < 180) gap = ADDR_W'($urandom_range(1, 4095));
        else if (c < 197) gap = ADDR_W'($urandom_range(4096, 65536));
        else gap = ADDR_W'($urandom_range(65537, 1 << 22));
        c = $urandom_range(99);
        if (c < 85) rd_len = ADDR_W'($urandom_range(1, 32768));
        else if (c < 97) rd_len = ADDR_W'($urandom_range(32769, 1 << 20));
        else if (c < 99) rd_len = '0;
        else rd_len = ADDR_W'($urandom_range(1 << 20, 1 << 24));
        put_word(OP_READ, sb.run_end + gap, rd_len, 1'($urandom_range(1)), took);
      end
      if (took) done++;
      // sender holds off mid-stream until the unit is empty
      if (p == 3 && done == 60 && !paused) begin
        paused = 1'b1;
        drain();
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    clk_i                 = 1'b0;
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = REG_REGION_SIZE;
    cfg_data_i            = '0;
    calm                  = 1'b0;
    cycles                = 0;
    evt_if.valid          = 1'b0;
    evt_if.opcode         = OP_READ;
    evt_if.read_offset    = '0;
    evt_if.read_length    = '0;
    evt_if.range_resident = 1'b0;
    res_if.ready          = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_part();
    for (int unsigned p = 0; p < N_PHASES; p++) random_phase(p, p == N_PHASES - 1);

    // wait for the last words and let the pipe settle before the final check
    drain();
    repeat (8) @(posedge clk_i);
    if (sb.expected_q.size() != 0) begin
      $error("%0d expected result words never arrived", sb.expected_q.size());
      sb.errors++;
    end
    $display("%0d words sent through probe, active and suspended modes", sb.n_words);
    $display("%0d prefetches, %0d probes, %0d rejected reads, %0d failures",
             sb.n_prefetch, sb.n_probe, sb.n_reject, sb.errors);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/sra_pkg.sv
rtl/sra_if.sv
rtl/sra_in_stage.sv
rtl/sra_policy.sv
rtl/sra_out_stage.sv
rtl/sequential_readahead_policy_unit.sv
tb/testbench.sv
